### sv/kpe_pkg.sv
// shared constants, types and coefficient functions for the king psf evaluator
// no dependencies; used by every module of the block
`default_nettype none
package kpe_pkg;

	localparam logic [31:0] GAMMA_ONE = 32'h0100_0000;
	localparam logic [55:0] OUT_MAX   = 56'hFF_FFFF_FFFF_FFFF;

	// stage counts of each unit
	localparam int RDIV_STAGES = 64;
	localparam int ADIV_STEPS  = 32;
	localparam int XDIV_STAGES = 104;
	localparam int NORM_STAGES = 7;
	localparam int LOG_STAGES  = 32;
	localparam int EXP_STAGES  = 32;
	localparam int FRONT_LAT   = RDIV_STAGES + 2 + XDIV_STAGES + 1 + NORM_STAGES;
	localparam int BACK_LAT    = LOG_STAGES + 2 + EXP_STAGES + 2;
	localparam int COMP_LAT    = FRONT_LAT + BACK_LAT;
	localparam int MIX_LAT     = 5;
	localparam int TOTAL_LAT   = COMP_LAT + MIX_LAT;

	// front end to back end of one component
	typedef struct packed {
		logic [31:0] mant;
		logic [6:0]  lint;
		logic [31:0] gamma;
		logic [31:0] aval;
		logic        gok;
	} front_out_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = n;
		res = '0;
		bt  = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-(k+1)) in q0.32, built by repeated square roots
	function automatic logic [31:0] exp_coef(input int k);
		logic [63:0] c;
		c = isqrt64(64'h8000_0000_0000_0000);
		for (int i = 0; i < k; i++) begin
			c = isqrt64({c[31:0], 32'h0});
		end
		return c[31:0];
	endfunction

endpackage
`default_nettype wire

### sv/kpe_front.sv
// component front end: sep/scale divider, square, divide by 2g, leading-one normalize
// also forms a = 1 - 1/g with its own divider; uses kpe_pkg
`default_nettype none
module kpe_front (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        sep,
	input  wire logic [31:0]        scale,
	input  wire logic [31:0]        gamma,
	output kpe_pkg::front_out_t     res
);

	localparam int RN = kpe_pkg::RDIV_STAGES;
	localparam int XN = kpe_pkg::XDIV_STAGES;
	localparam int NN = kpe_pkg::NORM_STAGES;

	logic [31:0] scl_in;
	assign scl_in = (scale == 32'd0) ? 32'd1 : scale;

	logic [31:0] rrem_s [RN];
	logic [63:0] rquo_s [RN];
	logic [31:0] rscl_s [RN];
	logic [31:0] rsep_s [RN];
	logic [31:0] rg_s   [RN];
	logic [31:0] arem_s [RN];
	logic [31:0] aquo_s [RN];

	// sep * 2^32 / scale, one quotient bit per stage; 2^56 / g rides alongside
	for (genvar i = 0; i < RN; i++) begin : g_rdiv
		logic [31:0] rem_i, scl_i, sep_i, g_i, arem_i, aquo_i;
		logic [63:0] quo_i;
		logic        sb;
		logic [32:0] trial;
		logic        ge;
		logic [31:0] arem_n, aquo_n;
		if (i == 0) begin : g_first
			assign rem_i  = '0;
			assign quo_i  = '0;
			assign scl_i  = scl_in;
			assign sep_i  = sep;
			assign g_i    = gamma;
			assign arem_i = kpe_pkg::GAMMA_ONE;
			assign aquo_i = '0;
		end else begin : g_next
			assign rem_i  = rrem_s[i-1];
			assign quo_i  = rquo_s[i-1];
			assign scl_i  = rscl_s[i-1];
			assign sep_i  = rsep_s[i-1];
			assign g_i    = rg_s[i-1];
			assign arem_i = arem_s[i-1];
			assign aquo_i = aquo_s[i-1];
		end
		if (i < 32) begin : g_sepbit
			assign sb = sep_i[31-i];
		end else begin : g_zerobit
			assign sb = 1'b0;
		end
		assign trial = {rem_i, sb};
		assign ge    = trial >= {1'b0, scl_i};
		if (i < kpe_pkg::ADIV_STEPS) begin : g_astep
			logic [32:0] atrial;
			logic        age;
			assign atrial = {arem_i, 1'b0};
			assign age    = atrial >= {1'b0, g_i};
			assign arem_n = age ? 32'(atrial - {1'b0, g_i}) : atrial[31:0];
			assign aquo_n = {aquo_i[30:0], age};
		end else begin : g_ahold
			assign arem_n = arem_i;
			assign aquo_n = aquo_i;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rrem_s[i] <= ge ? 32'(trial - {1'b0, scl_i}) : trial[31:0];
				rquo_s[i] <= {quo_i[62:0], ge};
				rscl_s[i] <= scl_i;
				rsep_s[i] <= sep_i;
				rg_s[i]   <= g_i;
				arem_s[i] <= arem_n;
				aquo_s[i] <= aquo_n;
			end
		end
	end

	// r squared from three partial products
	logic [63:0] p00_s65, p01_s65, p11_s65;
	logic [31:0] g_s65, a_s65;
	logic [63:0] r_last;
	assign r_last = rquo_s[RN-1];

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s65 <= r_last[31:0] * r_last[31:0];
			p01_s65 <= r_last[31:0] * r_last[63:32];
			p11_s65 <= r_last[63:32] * r_last[63:32];
			g_s65   <= rg_s[RN-1];
			a_s65   <= 32'(33'h1_0000_0000 - {1'b0, aquo_s[RN-1]});
		end
	end

	logic [127:0] sq_s66;
	logic [31:0]  g_s66, a_s66;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s66 <= {p11_s65, 64'h0} + {31'h0, p01_s65, 33'h0} + {64'h0, p00_s65};
			g_s66  <= g_s65;
			a_s66  <= a_s65;
		end
	end

	// r^2 / 2g: numerator and quotient share one shifting word
	logic [32:0]  xrem_s [XN];
	logic [103:0] xnq_s  [XN];
	logic [31:0]  xg_s   [XN];
	logic [31:0]  xa_s   [XN];

	for (genvar j = 0; j < XN; j++) begin : g_xdiv
		logic [32:0]  rem_j;
		logic [103:0] nq_j;
		logic [31:0]  g_j, a_j;
		logic [33:0]  trial;
		logic [32:0]  dd;
		logic         ge;
		if (j == 0) begin : g_first
			assign rem_j = {9'h0, sq_s66[127:104]};
			assign nq_j  = sq_s66[103:0];
			assign g_j   = g_s66;
			assign a_j   = a_s66;
		end else begin : g_next
			assign rem_j = xrem_s[j-1];
			assign nq_j  = xnq_s[j-1];
			assign g_j   = xg_s[j-1];
			assign a_j   = xa_s[j-1];
		end
		assign dd    = {g_j, 1'b0};
		assign trial = {rem_j, nq_j[103]};
		assign ge    = trial >= {1'b0, dd};
		always_ff @(posedge clk) begin
			if (en) begin
				xrem_s[j] <= ge ? 33'(trial - {1'b0, dd}) : trial[32:0];
				xnq_s[j]  <= {nq_j[102:0], ge};
				xg_s[j]   <= g_j;
				xa_s[j]   <= a_j;
			end
		end
	end

	// x = 1 + u/g in q.40
	logic [104:0] x_s171;
	logic [31:0]  g_s171, a_s171;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s171 <= {1'b0, xnq_s[XN-1]} + (105'd1 << 40);
			g_s171 <= xg_s[XN-1];
			a_s171 <= xa_s[XN-1];
		end
	end

	// leading-one search, halving the shift each stage
	logic [104:0] nw_s  [NN];
	logic [6:0]   nlz_s [NN];
	logic [31:0]  ng_s  [NN];
	logic [31:0]  na_s  [NN];

	for (genvar t = 0; t < NN; t++) begin : g_norm
		localparam int K = 64 >> t;
		logic [104:0] w_t;
		logic [6:0]   lz_t;
		logic [31:0]  g_t, a_t;
		logic         z;
		if (t == 0) begin : g_first
			assign w_t  = x_s171;
			assign lz_t = '0;
			assign g_t  = g_s171;
			assign a_t  = a_s171;
		end else begin : g_next
			assign w_t  = nw_s[t-1];
			assign lz_t = nlz_s[t-1];
			assign g_t  = ng_s[t-1];
			assign a_t  = na_s[t-1];
		end
		assign z = (w_t[104 -: K] == '0);
		always_ff @(posedge clk) begin
			if (en) begin
				nw_s[t]  <= z ? (w_t << K) : w_t;
				nlz_s[t] <= z ? 7'(lz_t + 7'(K)) : lz_t;
				ng_s[t]  <= g_t;
				na_s[t]  <= a_t;
			end
		end
	end

	assign res.mant  = nw_s[NN-1][104:73];
	assign res.lint  = 7'(7'd64 - nlz_s[NN-1]);
	assign res.gamma = ng_s[NN-1];
	assign res.aval  = na_s[NN-1];
	assign res.gok   = ng_s[NN-1] > kpe_pkg::GAMMA_ONE;

endmodule
`default_nettype wire

### sv/kpe_back.sv
// component back end: log2 by repeated squaring, g*log2 product, exp2 by constant
// multiplies, final (1-1/g) weighting; uses kpe_pkg
`default_nettype none
module kpe_back (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire kpe_pkg::front_out_t fin,
	output logic [31:0]             ap
);

	localparam int LN = kpe_pkg::LOG_STAGES;
	localparam int EN = kpe_pkg::EXP_STAGES;

	logic [31:0] lm_s [LN];
	logic [31:0] lf_s [LN];
	logic [6:0]  li_s [LN];
	logic [31:0] lg_s [LN];
	logic [31:0] la_s [LN];
	logic        lok_s[LN];

	// one fraction bit of log2 per stage
	for (genvar i = 0; i < LN; i++) begin : g_log
		logic [31:0] m_i, f_i, g_i, a_i;
		logic [6:0]  li_i;
		logic        ok_i;
		logic [63:0] mm;
		logic        b;
		if (i == 0) begin : g_first
			assign m_i  = fin.mant;
			assign f_i  = '0;
			assign li_i = fin.lint;
			assign g_i  = fin.gamma;
			assign a_i  = fin.aval;
			assign ok_i = fin.gok;
		end else begin : g_next
			assign m_i  = lm_s[i-1];
			assign f_i  = lf_s[i-1];
			assign li_i = li_s[i-1];
			assign g_i  = lg_s[i-1];
			assign a_i  = la_s[i-1];
			assign ok_i = lok_s[i-1];
		end
		assign mm = m_i * m_i;
		assign b  = mm[63];
		always_ff @(posedge clk) begin
			if (en) begin
				lm_s[i]  <= b ? mm[63:32] : mm[62:31];
				lf_s[i]  <= {f_i[30:0], b};
				li_s[i]  <= li_i;
				lg_s[i]  <= g_i;
				la_s[i]  <= a_i;
				lok_s[i] <= ok_i;
			end
		end
	end

	logic [63:0] pf_s33;
	logic [38:0] pl_s33;
	logic [31:0] a_s33;
	logic        ok_s33;
	always_ff @(posedge clk) begin
		if (en) begin
			pf_s33 <= lg_s[LN-1] * lf_s[LN-1];
			pl_s33 <= lg_s[LN-1] * li_s[LN-1];
			a_s33  <= la_s[LN-1];
			ok_s33 <= lok_s[LN-1];
		end
	end

	logic [71:0] y;
	assign y = {8'h0, pf_s33} + {1'b0, pl_s33, 32'h0};

	logic [31:0] f_s34;
	logic [5:0]  n_s34;
	logic        huge_s34;
	logic [31:0] a_s34;
	logic        ok_s34;
	always_ff @(posedge clk) begin
		if (en) begin
			f_s34    <= y[55:24];
			n_s34    <= y[61:56];
			huge_s34 <= y[71:56] > 16'd32;
			a_s34    <= a_s33;
			ok_s34   <= ok_s33;
		end
	end

	logic [32:0] ep_s  [EN];
	logic [31:0] ef_s  [EN];
	logic [5:0]  en_s  [EN];
	logic        eh_s  [EN];
	logic [31:0] ea_s  [EN];
	logic        eok_s [EN];

	// exp2 of the fraction, one coefficient per fraction bit
	for (genvar k = 0; k < EN; k++) begin : g_exp
		localparam logic [31:0] CK = kpe_pkg::exp_coef(k);
		logic [32:0] p_k;
		logic [31:0] f_k, a_k;
		logic [5:0]  n_k;
		logic        h_k, ok_k;
		logic [64:0] prod;
		if (k == 0) begin : g_first
			assign p_k  = 33'h1_0000_0000;
			assign f_k  = f_s34;
			assign n_k  = n_s34;
			assign h_k  = huge_s34;
			assign a_k  = a_s34;
			assign ok_k = ok_s34;
		end else begin : g_next
			assign p_k  = ep_s[k-1];
			assign f_k  = ef_s[k-1];
			assign n_k  = en_s[k-1];
			assign h_k  = eh_s[k-1];
			assign a_k  = ea_s[k-1];
			assign ok_k = eok_s[k-1];
		end
		assign prod = p_k * CK;
		always_ff @(posedge clk) begin
			if (en) begin
				ep_s[k]  <= f_k[31-k] ? prod[64:32] : p_k;
				ef_s[k]  <= f_k;
				en_s[k]  <= n_k;
				eh_s[k]  <= h_k;
				ea_s[k]  <= a_k;
				eok_s[k] <= ok_k;
			end
		end
	end

	logic [32:0] p_s67;
	logic [31:0] a_s67;
	logic        ok_s67;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s67  <= eh_s[EN-1] ? 33'h0 : (ep_s[EN-1] >> en_s[EN-1]);
			a_s67  <= ea_s[EN-1];
			ok_s67 <= eok_s[EN-1];
		end
	end

	logic [64:0] aprod;
	assign aprod = a_s67 * p_s67;

	logic [31:0] ap_s68;
	always_ff @(posedge clk) begin
		if (en) begin
			ap_s68 <= ok_s67 ? aprod[63:32] : 32'h0;
		end
	end

	assign ap = ap_s68;

endmodule
`default_nettype wire

### sv/kpe_mix.sv
// weighting of both components by the normalizations, exact sum and saturation
// 32-bit partial products over five stages; uses kpe_pkg
`default_nettype none
module kpe_mix (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] apc,
	input  wire logic [31:0] apt,
	input  wire logic [47:0] norm,
	input  wire logic [31:0] ratio,
	output logic [55:0]      psf,
	output logic             sat
);

	logic [63:0] pcl_s1, rt_s1;
	logic [47:0] pch_s1, norm_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			pcl_s1  <= norm[31:0] * apc;
			pch_s1  <= norm[47:32] * apc;
			rt_s1   <= ratio * apt;
			norm_s1 <= norm;
		end
	end

	logic [79:0] csum;
	assign csum = {pch_s1, 32'h0} + {16'h0, pcl_s1};

	logic [47:0] core_s2, norm_s2;
	logic [39:0] t_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			core_s2 <= csum[79:32];
			t_s2    <= rt_s1[63:24];
			norm_s2 <= norm_s1;
		end
	end

	logic [63:0] p0_s3;
	logic [39:0] p1_s3;
	logic [47:0] p2_s3;
	logic [23:0] p3_s3;
	logic [47:0] core_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s3   <= norm_s2[31:0] * t_s2[31:0];
			p1_s3   <= norm_s2[31:0] * t_s2[39:32];
			p2_s3   <= norm_s2[47:32] * t_s2[31:0];
			p3_s3   <= norm_s2[47:32] * t_s2[39:32];
			core_s3 <= core_s2;
		end
	end

	logic [87:0] tsum;
	assign tsum = {24'h0, p0_s3} + {16'h0, p1_s3, 32'h0} + {8'h0, p2_s3, 32'h0}
		+ {p3_s3, 64'h0};

	logic [55:0] tail_s4;
	logic [47:0] core_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			tail_s4 <= tsum[87:32];
			core_s4 <= core_s3;
		end
	end

	logic [56:0] total;
	assign total = {9'h0, core_s4} + {1'b0, tail_s4};

	logic [55:0] psf_s5;
	logic        sat_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			psf_s5 <= total[56] ? kpe_pkg::OUT_MAX : total[55:0];
			sat_s5 <= total[56];
		end
	end

	assign psf = psf_s5;
	assign sat = sat_s5;

endmodule
`default_nettype wire

### sv/king_psf_evaluator.sv
// top level of the two-component king psf evaluator
// instantiates kpe_front, kpe_back (one pair per component) and kpe_mix; uses kpe_pkg
//
// One word in, one word out, a new word every cycle unless the output word waits. The stages,
// in order: the separation divider, the square, the divide by 2g, forming and normalizing x,
// the log2 squaring chain, the g*log2 product, the exp2 multiply chain, shift and weighting,
// and the normalization products with the saturating sum. All stages advance together; the
// whole pipe, bubbles included, holds while the output word waits, and the input is held off
// for exactly those cycles. No configuration, no clearing after reset.
`default_nettype none
module king_psf_evaluator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] sep_radians,
	input  wire logic [31:0] core_scale,
	input  wire logic [31:0] tail_scale,
	input  wire logic [31:0] core_gamma,
	input  wire logic [31:0] tail_gamma,
	input  wire logic [47:0] core_norm,
	input  wire logic [31:0] tail_ratio,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [55:0]      psf_value,
	output logic             saturated
);

	localparam int CL = kpe_pkg::COMP_LAT;
	localparam int TL = kpe_pkg::TOTAL_LAT;

	logic vld_s [TL];
	logic adv;

	assign adv       = !vld_s[TL-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[TL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TL; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < TL; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// normalizations wait beside the component pipes
	logic [47:0] norm_s  [CL];
	logic [31:0] ratio_s [CL];
	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s[0]  <= core_norm;
			ratio_s[0] <= tail_ratio;
			for (int i = 1; i < CL; i++) begin
				norm_s[i]  <= norm_s[i-1];
				ratio_s[i] <= ratio_s[i-1];
			end
		end
	end

	kpe_pkg::front_out_t fc, ft;
	logic [31:0] apc, apt;

	kpe_front u_front_core (
		.clk   (clk),
		.en    (adv),
		.sep   (sep_radians),
		.scale (core_scale),
		.gamma (core_gamma),
		.res   (fc)
	);

	kpe_front u_front_tail (
		.clk   (clk),
		.en    (adv),
		.sep   (sep_radians),
		.scale (tail_scale),
		.gamma (tail_gamma),
		.res   (ft)
	);

	kpe_back u_back_core (
		.clk (clk),
		.en  (adv),
		.fin (fc),
		.ap  (apc)
	);

	kpe_back u_back_tail (
		.clk (clk),
		.en  (adv),
		.fin (ft),
		.ap  (apt)
	);

	kpe_mix u_mix (
		.clk   (clk),
		.en    (adv),
		.apc   (apc),
		.apt   (apt),
		.norm  (norm_s[CL-1]),
		.ratio (ratio_s[CL-1]),
		.psf   (psf_value),
		.sat   (saturated)
	);

`ifndef ASSERT_OFF
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> psf_value == kpe_pkg::OUT_MAX)
		else $error("saturated word without maximum value");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted word did not enter the pipe");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a waiting output word");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> out_valid && $stable(vld_s[0]))
		else $error("pipe moved during a stall");
`endif

endmodule
`default_nettype wire
